// ===== src/biquad_pkg.sv =====
`default_nettype none

package biquad_pkg;

   // field and datapath widths
   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_FRAC_BITS = 16;
   localparam int COEF_BITS      = 20;
   localparam int DELAY_BITS     = 32;
   localparam int PROD_BITS      = COEF_BITS + DELAY_BITS;
   // three products plus the rounding half
   localparam int ACC_BITS       = PROD_BITS + 2;
   localparam int SCALED_BITS    = ACC_BITS - COEF_FRAC_BITS;
   localparam int WSUM_BITS      = SCALED_BITS + 1;

   // register file
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B0 = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B1 = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_B2 = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_A1 = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEF_A2 = CSR_INDEX_BITS'(4);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FB_MUL1,
      ST_FB_MUL2,
      ST_FB_ADD,
      ST_FB_W,
      ST_FF_MUL2,
      ST_FF_MUL0,
      ST_FF_ADD,
      ST_FF_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_A1_W1,
      MUL_A2_W2,
      MUL_B1_W1,
      MUL_B2_W2,
      MUL_B0_W
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic        load_in;
      logic        mul_en;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        w_load;
      logic        out_write;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

endpackage

`default_nettype wire

// ===== src/biquad_ctrl.sv =====
`default_nettype none

module biquad_ctrl
   import biquad_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_FB_MUL1;
            end
         end
         ST_FB_MUL1: state_in = ST_FB_MUL2;
         ST_FB_MUL2: state_in = ST_FB_ADD;
         ST_FB_ADD:  state_in = ST_FB_W;
         ST_FB_W:    state_in = ST_FF_MUL2;
         ST_FF_MUL2: state_in = ST_FF_MUL0;
         ST_FF_MUL0: state_in = ST_FF_ADD;
         ST_FF_ADD:  state_in = ST_FF_OUT;
         ST_FF_OUT: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      cmd           = '0;
      cmd.mul_sel   = MUL_A1_W1;
      cmd.acc_op    = ACC_HOLD;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         ST_FB_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_A1_W1;
         end
         ST_FB_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_A2_W2;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_FB_ADD: begin
            cmd.acc_op  = ACC_ADD;
         end
         ST_FB_W: begin
            cmd.w_load  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_B1_W1;
         end
         ST_FF_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_B2_W2;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_FF_MUL0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_B0_W;
            cmd.acc_op  = ACC_ADD;
         end
         ST_FF_ADD: begin
            cmd.acc_op  = ACC_ADD;
         end
         ST_FF_OUT: begin
            cmd.out_write = !status.out_busy;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_out_not_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.out_write |-> !status.out_busy)
      else $error("result written over a pending result");

   a_start_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FB_MUL1) |-> $past(cmd.load_in))
      else $error("sequence started without an accepted transaction");
`endif

endmodule

`default_nettype wire

// ===== src/biquad_dp.sv =====
`default_nettype none

module biquad_dp
   import biquad_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   output status_type                     status,
   input  wire logic [SAMPLE_BITS-1:0]    req_tdata,
   input  wire logic                      req_tuser,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [COEF_BITS-1:0]      csr_wdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [SAMPLE_BITS-1:0]         rsp_tdata,
   output logic                           rsp_tuser
);

   localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1 << COEF_FRAC_BITS);
   localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1 << (COEF_FRAC_BITS - 1));
   localparam logic signed [WSUM_BITS-1:0] W_MAX =
      {{(WSUM_BITS-DELAY_BITS+1){1'b0}}, {(DELAY_BITS-1){1'b1}}};
   localparam logic signed [WSUM_BITS-1:0] W_MIN =
      {{(WSUM_BITS-DELAY_BITS+1){1'b1}}, {(DELAY_BITS-1){1'b0}}};
   localparam logic signed [SCALED_BITS-1:0] Y_MAX =
      {{(SCALED_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SCALED_BITS-1:0] Y_MIN =
      {{(SCALED_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [COEF_BITS-1:0]   coef_b0_ff, coef_b1_ff, coef_b2_ff;
   logic signed [COEF_BITS-1:0]   coef_a1_ff, coef_a2_ff;
   logic signed [DELAY_BITS-1:0]  delay_one_ff, delay_two_ff;
   logic signed [DELAY_BITS-1:0]  w_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic                          clip_ff;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic signed [ACC_BITS-1:0]    acc_ff;
   logic                          rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]        rsp_data_ff;
   logic                          rsp_clip_ff;

   logic signed [COEF_BITS-1:0]   mul_coef;
   logic signed [DELAY_BITS-1:0]  mul_val;
   logic signed [ACC_BITS-1:0]    prod_ext;
   logic signed [ACC_BITS-1:0]    acc_in;
   logic signed [SCALED_BITS-1:0] scaled;
   logic signed [WSUM_BITS-1:0]   wsum;
   logic signed [DELAY_BITS-1:0]  w_sat;
   logic                          w_clip;
   logic signed [SAMPLE_BITS-1:0] y_sat;
   logic                          y_clip;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff <= COEF_ONE;
         coef_b1_ff <= '0;
         coef_b2_ff <= '0;
         coef_a1_ff <= '0;
         coef_a2_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COEF_B0: coef_b0_ff <= csr_wdata;
            CSR_COEF_B1: coef_b1_ff <= csr_wdata;
            CSR_COEF_B2: coef_b2_ff <= csr_wdata;
            CSR_COEF_A1: coef_a1_ff <= csr_wdata;
            CSR_COEF_A2: coef_a2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MUL_A1_W1: begin mul_coef = coef_a1_ff; mul_val = delay_one_ff; end
         MUL_A2_W2: begin mul_coef = coef_a2_ff; mul_val = delay_two_ff; end
         MUL_B1_W1: begin mul_coef = coef_b1_ff; mul_val = delay_one_ff; end
         MUL_B2_W2: begin mul_coef = coef_b2_ff; mul_val = delay_two_ff; end
         MUL_B0_W:  begin mul_coef = coef_b0_ff; mul_val = w_ff;         end
         default:   begin mul_coef = '0;         mul_val = '0;           end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_coef * mul_val;
      end
   end

   assign prod_ext = {{(ACC_BITS-PROD_BITS){prod_ff[PROD_BITS-1]}}, prod_ff};

   // rounding half folded in on load so the scale is a plain floor shift
   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD: acc_in = prod_ext + ROUND_HALF;
         ACC_ADD:  acc_in = acc_ff + prod_ext;
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign scaled = acc_ff[ACC_BITS-1:COEF_FRAC_BITS];
   assign wsum   = {{(WSUM_BITS-SAMPLE_BITS){x_ff[SAMPLE_BITS-1]}}, x_ff}
                 - {scaled[SCALED_BITS-1], scaled};

   always_comb begin
      w_clip = 1'b0;
      if (wsum > W_MAX) begin
         w_sat  = W_MAX[DELAY_BITS-1:0];
         w_clip = 1'b1;
      end else if (wsum < W_MIN) begin
         w_sat  = W_MIN[DELAY_BITS-1:0];
         w_clip = 1'b1;
      end else begin
         w_sat  = wsum[DELAY_BITS-1:0];
      end
   end

   always_comb begin
      y_clip = 1'b0;
      if (scaled > Y_MAX) begin
         y_sat  = Y_MAX[SAMPLE_BITS-1:0];
         y_clip = 1'b1;
      end else if (scaled < Y_MIN) begin
         y_sat  = Y_MIN[SAMPLE_BITS-1:0];
         y_clip = 1'b1;
      end else begin
         y_sat  = scaled[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         x_ff <= req_tdata;
      end
      if (cmd.w_load) begin
         w_ff    <= w_sat;
         clip_ff <= w_clip;
      end
   end

   // delay line
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_one_ff <= '0;
         delay_two_ff <= '0;
      end else if (cmd.load_in && req_tuser) begin
         delay_one_ff <= '0;
         delay_two_ff <= '0;
      end else if (cmd.out_write) begin
         delay_two_ff <= delay_one_ff;
         delay_one_ff <= w_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_write) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_write) begin
         rsp_data_ff <= y_sat;
         rsp_clip_ff <= clip_ff | y_clip;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tuser       = rsp_clip_ff;
   assign status.out_busy = rsp_valid_ff && !rsp_tready;

`ifndef SYNTHESIS
   a_write_shows_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_write |=> rsp_tvalid)
      else $error("written result not presented");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_in && req_tuser) |=> (delay_one_ff == '0) && (delay_two_ff == '0))
      else $error("restart did not clear the delay line");
`endif

endmodule

`default_nettype wire

// ===== src/biquad_iir_filter.sv =====
// states: FB_MUL1, FB_MUL2, FB_ADD, FB_W, FF_MUL2, FF_MUL0, FF_ADD, FF_OUT, then
// the registered rsp_tvalid; FF_OUT waits while rsp is stalled, and a new sample
// is taken only in IDLE; all five products share one 20x32 multiplier,
// feedback first, then feedforward; reset: synchronous, active high; coefficients
// return to b0 = 1.0, others 0; the delay line clears and no result is pending
`default_nettype none

module biquad_iir_filter
   import biquad_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // input samples
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [SAMPLE_BITS-1:0]    req_tdata,   // sample_in
   input  wire logic                      req_tuser,   // restart
   // filtered samples
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [SAMPLE_BITS-1:0]         rsp_tdata,   // sample_out
   output logic                           rsp_tuser,   // clipped
   // coefficient writes: 0 b0, 1 b1, 2 b2, 3 a1, 4 a2, others ignored
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [COEF_BITS-1:0]      csr_wdata
);

   // controller drives the multiply/accumulate sequence, datapath holds state
   cmd_type    cmd;
   status_type status;

   biquad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // feedback w = x - round(a1*w1 + a2*w2), saturated to 32 bits
   // feedforward y = round(b1*w1 + b2*w2 + b0*w), saturated to the sample range
   biquad_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
